// ===== design/infix_to_postfix_converter_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the infix to postfix converter
// Shared property shapes used by the controller checks.
// ----------------------------------------------------------------------------
`ifndef INFIX_TO_POSTFIX_CONVERTER_TOP_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_TOP_ASSERT_SVH

// Same-cycle implication, idle during reset
`define ITP_ASSERT_IMPLY(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication, idle during reset
`define ITP_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ===== design/itp_pkg.sv =====
// ----------------------------------------------------------------------------
// itp_pkg
// Types, codes and the precedence function of the infix to postfix converter.
// ----------------------------------------------------------------------------
package itp_pkg;

   // Stack entry: operator code 0..4, or the left parenthesis mark
   typedef logic [2:0] code_type;

   // Token kinds on the request channel
   localparam logic [1:0] ACT_ARG    = 2'd0;
   localparam logic [1:0] ACT_OP     = 2'd1;
   localparam logic [1:0] ACT_LPAREN = 2'd2;
   localparam logic [1:0] ACT_RPAREN = 2'd3;

   // Result kinds
   localparam logic [1:0] KIND_ARG = 2'd0;
   localparam logic [1:0] KIND_OP  = 2'd1;
   localparam logic [1:0] KIND_ERR = 2'd2;

   // Error codes
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_OVERFLOW = 2'd1;
   localparam logic [1:0] ERR_RPAREN   = 2'd2;
   localparam logic [1:0] ERR_LPAREN   = 2'd3;

   // Operator codes
   localparam code_type OP_PLUS     = 3'd0;
   localparam code_type OP_MINUS    = 3'd1;
   localparam code_type OP_TIMES    = 3'd2;
   localparam code_type OP_DIVIDE   = 3'd3;
   localparam code_type OP_POWER    = 3'd4;
   localparam code_type LPAREN_MARK = 3'd5;

   // Controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_OP_POP,
      S_PUSH,
      S_RPAREN,
      S_FLUSH
   } state_type;

   // One result item without its framing bits
   typedef struct packed {
      logic [1:0]        kind;
      logic signed [31:0] value;
      code_type          op;
      logic [1:0]        err;
   } result_type;

   // Stack shift control from the controller to the row of cells
   typedef struct packed {
      logic     push;
      logic     pop;
      code_type code;
   } stk_ctrl_type;

   // Precedence level: plus/minus 1, times/divide 2, power 3
   function automatic logic [1:0] prec_of(input code_type code);
      logic [1:0] lvl;
      begin
         if (code <= OP_MINUS) begin
            lvl = 2'd1;
         end else if (code <= OP_DIVIDE) begin
            lvl = 2'd2;
         end else begin
            lvl = 2'd3;
         end
         return lvl;
      end
   endfunction

endpackage

// ===== design/itp_req_if.sv =====
// ----------------------------------------------------------------------------
// itp_req_if
// Request channel: one infix token per handshake.
// ----------------------------------------------------------------------------
interface itp_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         action;
   logic signed [31:0] arg_value;
   logic [2:0]         op_code;
   logic               end_of_expr;

   modport source (output valid, action, arg_value, op_code, end_of_expr, input ready);
   modport sink   (input valid, action, arg_value, op_code, end_of_expr, output ready);
endinterface

// ===== design/itp_rsp_if.sv =====
// ----------------------------------------------------------------------------
// itp_rsp_if
// Response channel: one postfix token or error item per handshake.
// ----------------------------------------------------------------------------
interface itp_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         out_kind;
   logic signed [31:0] out_value;
   logic [2:0]         out_op;
   logic               run_last;
   logic               expr_done;
   logic [1:0]         error_code;

   modport source (output valid, out_kind, out_value, out_op, run_last, expr_done,
                   error_code, input ready);
   modport sink   (input valid, out_kind, out_value, out_op, run_last, expr_done,
                   error_code, output ready);
endinterface

// ===== design/itp_cell.sv =====
// ----------------------------------------------------------------------------
// itp_cell
// One entry of the shifting operator stack; takes its upper neighbor on a
// push and its lower neighbor on a pop.
// ----------------------------------------------------------------------------
module itp_cell (
   input  logic                 clock,
   input  itp_pkg::stk_ctrl_type ctrl,
   input  itp_pkg::code_type    above,
   input  itp_pkg::code_type    below,
   output itp_pkg::code_type    code
);

   itp_pkg::code_type code_ff;
   itp_pkg::code_type code_in;

   // Shift down on push, up on pop, else hold
   always_comb begin
      if (ctrl.push) begin
         code_in = above;
      end else if (ctrl.pop) begin
         code_in = below;
      end else begin
         code_in = code_ff;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
   end

   assign code = code_ff;

endmodule

// ===== design/itp_ctrl.sv =====
// ----------------------------------------------------------------------------
// itp_ctrl
// Shunting-yard sequencer: walks one token through pops and pushes of the
// cell stack, one step a cycle while the result stages have room, and
// frames results through a pending stage and the response register.
// ----------------------------------------------------------------------------
`include "infix_to_postfix_converter_top_assert.svh"

module itp_ctrl #(
   parameter int STACK_DEPTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   itp_req_if.sink               req_chan,
   itp_rsp_if.source             rsp_chan,
   output itp_pkg::stk_ctrl_type stk_ctrl,
   input  itp_pkg::code_type     top_code
);

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STACK_DEPTH);

   itp_pkg::state_type  state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   itp_pkg::code_type   tok_code_ff, tok_code_in;
   logic                tok_last_ff, tok_last_in;
   logic                emitted_ff, emitted_in;
   logic                open_left_ff, open_left_in;
   itp_pkg::result_type pend_ff, pend_in;
   logic                pend_valid_ff, pend_valid_in;
   logic                pend_last_ff, pend_last_in;
   logic                pend_done_ff, pend_done_in;
   itp_pkg::result_type rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                rsp_done_ff, rsp_done_in;

   logic                out_free, go, accept, move;
   logic                empty, full, top_lp, pop_cond;
   logic                emit, do_push, do_pop;
   itp_pkg::result_type emit_res;
   itp_pkg::state_type  end_state;

   // Stack and handshake status
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign go        = !pend_valid_ff || out_free;
   assign accept    = req_chan.valid && req_chan.ready;
   assign empty     = (count_ff == '0);
   assign full      = (count_ff >= DEPTH_C);
   assign top_lp    = (top_code == itp_pkg::LPAREN_MARK);
   assign pop_cond  = !empty && !top_lp &&
                      (itp_pkg::prec_of(top_code) >= itp_pkg::prec_of(tok_code_ff));
   assign end_state = tok_last_ff ? itp_pkg::S_FLUSH : itp_pkg::S_IDLE;

   assign req_chan.ready = (state_ff == itp_pkg::S_IDLE) && go;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         itp_pkg::S_IDLE: begin
            if (accept) begin
               case (req_chan.action)
                  itp_pkg::ACT_ARG: begin
                     state_in = req_chan.end_of_expr ? itp_pkg::S_FLUSH : itp_pkg::S_IDLE;
                  end
                  itp_pkg::ACT_OP: begin
                     if (req_chan.op_code <= itp_pkg::OP_POWER) begin
                        state_in = itp_pkg::S_OP_POP;
                     end else begin
                        state_in = req_chan.end_of_expr ? itp_pkg::S_FLUSH
                                                        : itp_pkg::S_IDLE;
                     end
                  end
                  itp_pkg::ACT_LPAREN: begin
                     state_in = itp_pkg::S_PUSH;
                  end
                  default: begin
                     state_in = itp_pkg::S_RPAREN;
                  end
               endcase
            end
         end
         itp_pkg::S_OP_POP: begin
            if (go && !pop_cond) begin
               state_in = itp_pkg::S_PUSH;
            end
         end
         itp_pkg::S_PUSH: begin
            if (go) begin
               state_in = end_state;
            end
         end
         itp_pkg::S_RPAREN: begin
            if (go && (empty || top_lp)) begin
               state_in = end_state;
            end
         end
         itp_pkg::S_FLUSH: begin
            if (go && empty) begin
               state_in = itp_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = itp_pkg::S_IDLE;
         end
      endcase
   end

   // Step outputs: result to emit and stack moves
   always_comb begin
      emit     = 1'b0;
      do_push  = 1'b0;
      do_pop   = 1'b0;
      emit_res = '0;
      case (state_ff)
         itp_pkg::S_IDLE: begin
            if (accept && (req_chan.action == itp_pkg::ACT_ARG)) begin
               emit           = 1'b1;
               emit_res.kind  = itp_pkg::KIND_ARG;
               emit_res.value = req_chan.arg_value;
            end
         end
         itp_pkg::S_OP_POP: begin
            if (go && pop_cond) begin
               do_pop        = 1'b1;
               emit          = 1'b1;
               emit_res.kind = itp_pkg::KIND_OP;
               emit_res.op   = top_code;
            end
         end
         itp_pkg::S_PUSH: begin
            if (go) begin
               if (full) begin
                  emit          = 1'b1;
                  emit_res.kind = itp_pkg::KIND_ERR;
                  emit_res.err  = itp_pkg::ERR_OVERFLOW;
               end else begin
                  do_push = 1'b1;
               end
            end
         end
         itp_pkg::S_RPAREN: begin
            if (go) begin
               if (empty) begin
                  emit          = 1'b1;
                  emit_res.kind = itp_pkg::KIND_ERR;
                  emit_res.err  = itp_pkg::ERR_RPAREN;
               end else begin
                  do_pop = 1'b1;
                  if (!top_lp) begin
                     emit          = 1'b1;
                     emit_res.kind = itp_pkg::KIND_OP;
                     emit_res.op   = top_code;
                  end
               end
            end
         end
         itp_pkg::S_FLUSH: begin
            if (go) begin
               if (!empty) begin
                  do_pop = 1'b1;
                  if (!top_lp) begin
                     emit          = 1'b1;
                     emit_res.kind = itp_pkg::KIND_OP;
                     emit_res.op   = top_code;
                  end
               end else if (open_left_ff) begin
                  emit          = 1'b1;
                  emit_res.kind = itp_pkg::KIND_ERR;
                  emit_res.err  = itp_pkg::ERR_LPAREN;
               end else if (!emitted_ff) begin
                  // empty end: marker item so the expression end is seen
                  emit          = 1'b1;
                  emit_res.kind = itp_pkg::KIND_ERR;
                  emit_res.err  = itp_pkg::ERR_NONE;
               end
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   // Advance pending to response register when the response side has room and
   // either a new result arrives or the token is finished
   assign move = pend_valid_ff && out_free && ((state_ff == itp_pkg::S_IDLE) || emit);

   assign stk_ctrl.push = do_push;
   assign stk_ctrl.pop  = do_pop;
   assign stk_ctrl.code = tok_code_ff;

   // Token, stack count and result staging next values
   always_comb begin
      tok_code_in  = tok_code_ff;
      tok_last_in  = tok_last_ff;
      emitted_in   = emitted_ff | emit;
      open_left_in = open_left_ff | ((state_ff == itp_pkg::S_FLUSH) && do_pop && top_lp);
      if (accept) begin
         tok_code_in  = (req_chan.action == itp_pkg::ACT_LPAREN) ? itp_pkg::LPAREN_MARK
                                                                : req_chan.op_code;
         tok_last_in  = req_chan.end_of_expr;
         emitted_in   = (req_chan.action == itp_pkg::ACT_ARG);
         open_left_in = 1'b0;
      end

      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);

      pend_valid_in = emit ? 1'b1 : (move ? 1'b0 : pend_valid_ff);
      pend_in       = emit ? emit_res : pend_ff;
      // Mark the held result as the token's last once the token finishes
      pend_last_in  = (state_in == itp_pkg::S_IDLE);
      if (state_in != itp_pkg::S_IDLE) begin
         pend_done_in = 1'b0;
      end else if (state_ff != itp_pkg::S_IDLE) begin
         pend_done_in = tok_last_ff;
      end else if (accept) begin
         pend_done_in = req_chan.end_of_expr;
      end else begin
         pend_done_in = pend_done_ff;
      end

      rsp_in       = move ? pend_ff : rsp_ff;
      rsp_last_in  = move ? pend_last_ff : rsp_last_ff;
      rsp_done_in  = move ? pend_done_ff : rsp_done_ff;
      rsp_valid_in = move ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= itp_pkg::S_IDLE;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      tok_code_ff  <= tok_code_in;
      tok_last_ff  <= tok_last_in;
      emitted_ff   <= emitted_in;
      open_left_ff <= open_left_in;
      pend_ff      <= pend_in;
      pend_last_ff <= pend_last_in;
      pend_done_ff <= pend_done_in;
      rsp_ff       <= rsp_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_done_ff  <= rsp_done_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.out_kind   = rsp_ff.kind;
   assign rsp_chan.out_value  = rsp_ff.value;
   assign rsp_chan.out_op     = rsp_ff.op;
   assign rsp_chan.error_code = rsp_ff.err;
   assign rsp_chan.run_last   = rsp_last_ff;
   assign rsp_chan.expr_done  = rsp_done_ff;

   // Checks
   `ITP_ASSERT_IMPLY(a_count_max, clock, reset, 1'b1, count_ff <= DEPTH_C, "stack count beyond depth")
   `ITP_ASSERT_IMPLY(a_push_room, clock, reset, do_push, !full, "push onto a full stack")
   `ITP_ASSERT_IMPLY(a_pop_data, clock, reset, do_pop, !empty, "pop from an empty stack")
   `ITP_ASSERT_NEXT(a_rsp_load, clock, reset, move, rsp_valid_ff, "moved result not presented")
   `ITP_ASSERT_IMPLY(a_idle_last, clock, reset, (state_ff == itp_pkg::S_IDLE) && pend_valid_ff, pend_last_ff, "finished token result not marked last")

endmodule

// ===== design/infix_to_postfix_converter_top.sv =====
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_top
// Shunting-yard converter: infix tokens in, postfix tokens and errors out.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one infix token per request (argument, operator, left or
//   right parenthesis, with an end-of-expression flag). rsp_chan returns the
//   postfix tokens; run_last marks the last result of each request and
//   expr_done the final result of an expression. Error items report stack
//   overflow, an unmatched right parenthesis and a leftover left parenthesis.
// Timing:
//   An argument is taken in idle. An operator pops each stacked operator of
//   equal or higher precedence, then pushes itself; a left parenthesis is
//   pushed; a right parenthesis pops entries through its left parenthesis.
//   The end-of-expression flush pops every entry. The sequencer pops or
//   pushes one stack entry per cycle unless the result stages are full. A
//   result waits in the pending stage until the next one is made, or until
//   the request ends with room in the response register, which it then enters.
// Reset:
//   Synchronous reset empties the stack count and drops staged results; the
//   stack cells keep stale codes that are never read.
// Stall:
//   With the response stalled, one result waits in the response register and
//   one in the pending stage; the sequencer then holds until space frees up.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_top #(
   parameter int STACK_DEPTH = 32
) (
   input logic       clock,
   input logic       reset,
   itp_req_if.sink   req_chan,
   itp_rsp_if.source rsp_chan
);

   itp_pkg::stk_ctrl_type stk_ctrl;
   itp_pkg::code_type     codes [STACK_DEPTH];

   // Sequencer
   itp_ctrl #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .stk_ctrl (stk_ctrl),
      .top_code (codes[0])
   );

   // Operator stack: row of cells, top at index zero
   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      itp_pkg::code_type above;
      itp_pkg::code_type below;

      if (i == 0) begin : g_top
         assign above = stk_ctrl.code;
      end else begin : g_mid
         assign above = codes[i-1];
      end

      if (i == STACK_DEPTH - 1) begin : g_bottom
         assign below = '0;
      end else begin : g_inner
         assign below = codes[i+1];
      end

      itp_cell u_cell (
         .clock (clock),
         .ctrl  (stk_ctrl),
         .above (above),
         .below (below),
         .code  (codes[i])
      );
   end

endmodule
